// File: design/pfa_pkg.sv
// Shared types and constants for the page frame allocator.
// Used by the controller, the datapath and the top level.
package pfa_pkg;

   // Geometry: frame index width is fixed by the page index field
   localparam int PAGE_W    = 12;
   localparam int NUM_PAGES = 1 << PAGE_W;
   localparam int COUNT_W   = 16;
   localparam int TOTAL_W   = PAGE_W + 1;
   localparam int OP_W      = 3;
   localparam int PMEM_W    = COUNT_W + 1;   // {on_list, count}

   localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE       = 3'd1;
   localparam logic [OP_W-1:0] OP_FORCE_FREE = 3'd2;
   localparam logic [OP_W-1:0] OP_SHARE_ADD  = 3'd3;
   localparam logic [OP_W-1:0] OP_SHARE_SUB  = 3'd4;

   // Controller to datapath commands
   typedef struct packed {
      logic init_step;   // write one entry of the reset image
      logic accept;      // latch the request word
      logic ring_rd;     // read the free ring at the head
      logic page_rd;     // read the page entry
      logic commit;      // write back and load the response register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic init_last;   // last entry of the reset image is being written
      logic out_free;    // response register can take a new word
   } status_type;

endpackage

// File: design/pfa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pfa_ctrl.sv
// Sequencing state machine of the page frame allocator.
// Depends on pfa_pkg for the command and status structs.
module pfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pfa_pkg::status_type status,
   output pfa_pkg::cmd_type    cmd
);
   import pfa_pkg::*;

   typedef enum logic [4:0] {
      ST_INIT    = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_RING_RD = 5'b00100,
      ST_PAGE_RD = 5'b01000,
      ST_EXEC    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (status.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_RING_RD;
            end
         end
         ST_RING_RD: begin
            cmd.ring_rd = 1'b1;
            state_in    = ST_PAGE_RD;
         end
         ST_PAGE_RD: begin
            cmd.page_rd = 1'b1;
            state_in    = ST_EXEC;
         end
         ST_EXEC: begin
            // hold until the response register has room
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/pfa_datapath.sv
// Datapath: free ring and page memories, pointers, free total, update logic
// and the response register. Depends on pfa_pkg and pfa_ram.
module pfa_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  pfa_pkg::cmd_type               cmd,
   output pfa_pkg::status_type            status,
   input  logic                           csr_write_enable,
   input  logic [pfa_pkg::PAGE_W-1:0]     csr_write_data,
   input  logic [pfa_pkg::OP_W-1:0]       req_operation,
   input  logic [pfa_pkg::PAGE_W-1:0]     req_page_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pfa_pkg::PAGE_W-1:0]     rsp_result_page,
   output logic                           rsp_success,
   output logic                           rsp_page_released,
   output logic [pfa_pkg::COUNT_W-1:0]    rsp_share_count,
   output logic [pfa_pkg::TOTAL_W-1:0]    rsp_free_pages
);
   import pfa_pkg::*;

   // Control state
   logic [PAGE_W-1:0]  init_ff, init_in;
   logic [PAGE_W-1:0]  head_ff, head_in;
   logic [PAGE_W-1:0]  tail_ff, tail_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [PAGE_W-1:0]  prot_ff, prot_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Request word and response word
   logic [OP_W-1:0]    op_ff, op_in;
   logic [PAGE_W-1:0]  idx_ff, idx_in;
   logic [PAGE_W-1:0]  rpage_ff, rpage_in;
   logic               ok_ff, ok_in;
   logic               rel_ff, rel_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [TOTAL_W-1:0] free_ff, free_in;

   // Memory ports
   logic               ring_wr_en;
   logic [PAGE_W-1:0]  ring_wr_addr;
   logic [PAGE_W-1:0]  ring_wr_data;
   logic [PAGE_W-1:0]  ring_rd_data;
   logic               page_wr_en;
   logic [PAGE_W-1:0]  page_wr_addr;
   logic [PMEM_W-1:0]  page_wr_data;
   logic [PAGE_W-1:0]  page_rd_addr;
   logic [PMEM_W-1:0]  page_rd_data;

   // Update results
   logic               is_alloc;
   logic [PAGE_W-1:0]  target;
   logic [COUNT_W-1:0] cur_cnt;
   logic               cur_on;
   logic [COUNT_W-1:0] new_cnt;
   logic               new_on;
   logic               upd_ok;
   logic               upd_wr;
   logic               push_head;
   logic               push_tail;

   pfa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_en   (cmd.ring_rd),
      .rd_addr (head_ff),
      .rd_data (ring_rd_data)
   );

   pfa_ram #(.WIDTH(PMEM_W), .DEPTH(NUM_PAGES)) u_page (
      .clock   (clock),
      .wr_en   (page_wr_en),
      .wr_addr (page_wr_addr),
      .wr_data (page_wr_data),
      .rd_en   (cmd.page_rd),
      .rd_addr (page_rd_addr),
      .rd_data (page_rd_data)
   );

   // Alloc works on the frame read from the ring head
   assign is_alloc     = (op_ff == OP_ALLOC);
   assign target       = is_alloc ? ring_rd_data : idx_ff;
   assign page_rd_addr = target;
   assign cur_cnt      = page_rd_data[COUNT_W-1:0];
   assign cur_on       = page_rd_data[COUNT_W];

   // Per-operation update of the frame entry
   always_comb begin
      new_cnt   = cur_cnt;
      new_on    = cur_on;
      upd_ok    = 1'b0;
      upd_wr    = 1'b0;
      push_head = 1'b0;
      push_tail = 1'b0;
      case (op_ff)
         OP_ALLOC: begin
            if (total_ff != '0) begin
               upd_ok = 1'b1;
               upd_wr = 1'b1;
               new_on = 1'b0;
               if (cur_cnt != CNT_MAX) begin
                  new_cnt = cur_cnt + 1'b1;
               end
            end
         end
         OP_FREE: begin
            if (cur_cnt != '0) begin
               upd_ok  = 1'b1;
               upd_wr  = 1'b1;
               new_cnt = cur_cnt - 1'b1;
               // last reference gone: back to the head, except the protected page
               if (cur_cnt == COUNT_W'(1) && idx_ff != prot_ff && !cur_on) begin
                  push_head = 1'b1;
                  new_on    = 1'b1;
               end
            end
         end
         OP_FORCE_FREE: begin
            if (!cur_on) begin
               upd_ok    = 1'b1;
               upd_wr    = 1'b1;
               push_tail = 1'b1;
               new_cnt   = '0;
               new_on    = 1'b1;
            end
         end
         OP_SHARE_ADD: begin
            if (cur_cnt != CNT_MAX) begin
               upd_ok  = 1'b1;
               upd_wr  = 1'b1;
               new_cnt = cur_cnt + 1'b1;
            end
         end
         OP_SHARE_SUB: begin
            if (cur_cnt != '0) begin
               upd_ok  = 1'b1;
               upd_wr  = 1'b1;
               new_cnt = cur_cnt - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Memory write ports: reset image during init, else write-back on commit
   assign ring_wr_en   = cmd.init_step | (cmd.commit & (push_head | push_tail));
   assign ring_wr_addr = cmd.init_step ? init_ff
                       : (push_head ? PAGE_W'(head_ff - 1'b1) : tail_ff);
   assign ring_wr_data = cmd.init_step ? init_ff : idx_ff;
   assign page_wr_en   = cmd.init_step | (cmd.commit & upd_wr);
   assign page_wr_addr = cmd.init_step ? init_ff : target;
   assign page_wr_data = cmd.init_step ? {1'b1, {COUNT_W{1'b0}}} : {new_on, new_cnt};

   // Pointers, free total, init sweep, protected page
   always_comb begin
      init_in  = init_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      total_in = total_ff;
      prot_in  = csr_write_enable ? csr_write_data : prot_ff;
      if (cmd.init_step) begin
         init_in = PAGE_W'(init_ff + 1'b1);
      end
      if (cmd.commit) begin
         if (is_alloc && upd_ok) begin
            head_in  = PAGE_W'(head_ff + 1'b1);
            total_in = TOTAL_W'(total_ff - 1'b1);
         end
         if (push_head) begin
            head_in  = PAGE_W'(head_ff - 1'b1);
            total_in = TOTAL_W'(total_ff + 1'b1);
         end
         if (push_tail) begin
            tail_in  = PAGE_W'(tail_ff + 1'b1);
            total_in = TOTAL_W'(total_ff + 1'b1);
         end
      end
   end

   // Request latch and response word
   always_comb begin
      op_in        = cmd.accept ? req_operation : op_ff;
      idx_in       = cmd.accept ? req_page_index : idx_ff;
      rpage_in     = rpage_ff;
      ok_in        = ok_ff;
      rel_in       = rel_ff;
      cnt_in       = cnt_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         ok_in        = upd_ok;
         rel_in       = push_head | push_tail;
         free_in      = total_in;
         if (is_alloc) begin
            rpage_in = upd_ok ? ring_rd_data : '0;
            cnt_in   = upd_ok ? new_cnt : '0;
         end else begin
            rpage_in = idx_ff;
            cnt_in   = new_cnt;
         end
      end
   end

   assign status.init_last = (init_ff == PAGE_W'(NUM_PAGES - 1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         total_ff     <= TOTAL_W'(NUM_PAGES);
         prot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_ff      <= init_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         prot_ff      <= prot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      rpage_ff <= rpage_in;
      ok_ff    <= ok_in;
      rel_ff   <= rel_in;
      cnt_ff   <= cnt_in;
      free_ff  <= free_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_page   = rpage_ff;
   assign rsp_success       = ok_ff;
   assign rsp_page_released = rel_ff;
   assign rsp_share_count   = cnt_ff;
   assign rsp_free_pages    = free_ff;

endmodule

// File: design/refcounted_page_frame_allocator_unit.sv
// Top level of the reference-counted page frame allocator.
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath (which uses pfa_ram).
//
// After reset the unit writes every entry of the initial free ring
// (slot i holds frame i) and the page table (count 0, on the free list);
// req_stall stays high during that sweep, while csr writes are taken at any
// time. After that each request word runs through these steps before the
// next acceptance: accept, registered read of the free ring at the head,
// registered read of the frame's count and free flag, then the write-back
// that also loads the response register. The single response register lets
// the next request be accepted while a response word is still stalled; a
// request then waits in its write-back cycle until that register is free.
module refcounted_page_frame_allocator_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [pfa_pkg::PAGE_W-1:0]     csr_write_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [pfa_pkg::OP_W-1:0]       req_operation,
   input  logic [pfa_pkg::PAGE_W-1:0]     req_page_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pfa_pkg::PAGE_W-1:0]     rsp_result_page,
   output logic                           rsp_success,
   output logic                           rsp_page_released,
   output logic [pfa_pkg::COUNT_W-1:0]    rsp_share_count,
   output logic [pfa_pkg::TOTAL_W-1:0]    rsp_free_pages
);
   import pfa_pkg::*;

   cmd_type    cmd;
   status_type status;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pfa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_operation     (req_operation),
      .req_page_index    (req_page_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_page   (rsp_result_page),
      .rsp_success       (rsp_success),
      .rsp_page_released (rsp_page_released),
      .rsp_share_count   (rsp_share_count),
      .rsp_free_pages    (rsp_free_pages)
   );

endmodule
